/* sv/lgs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] CFG_WRAP = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_COLS = 2'd2;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_STEP,
        OP_READ,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TOP,
        ST_ROW0,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  row_index;
        logic [63:0] row_bits;
    } t_in_item;

    typedef struct packed {
        logic [63:0] row_out;
        logic [31:0] generation_count;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic        row_ok;
        logic [5:0]  row_index;
        logic [63:0] row_bits;
    } t_cmd;

    function automatic logic life_rule(input logic self_alive, input logic [3:0] count);
        life_rule = (count == BIRTH_COUNT) || (self_alive && (count == SURVIVE_COUNT));
    endfunction

endpackage

`default_nettype wire

/* sv/lgs_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgs_front #(
    parameter int MAX_ROWS = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  lgs_pkg::t_in_item  i_in,
    output logic               o_full,
    output logic               o_cmd_valid,
    output lgs_pkg::t_cmd      o_cmd,
    input  wire                i_cmd_pop
);

    lgs_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    lgs_pkg::t_cmd w_cls;
    logic          w_wr;
    logic          w_rd;

    // decode the item before it enters the queue
    always_comb begin
        w_cls.row_index = i_in.row_index;
        w_cls.row_bits  = i_in.row_bits;
        w_cls.row_ok    = (int'(i_in.row_index) < MAX_ROWS);
        case (i_in.kind)
            lgs_pkg::KIND_LOAD: w_cls.op = lgs_pkg::OP_LOAD;
            lgs_pkg::KIND_STEP: w_cls.op = lgs_pkg::OP_STEP;
            lgs_pkg::KIND_READ: w_cls.op = lgs_pkg::OP_READ;
            default:            w_cls.op = lgs_pkg::OP_NONE;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

`default_nettype wire

/* sv/lgs_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgs_back #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_wrap,
    input  wire  [6:0]         i_cfg_rows,
    input  wire  [6:0]         i_cfg_cols,
    input  wire                i_cmd_valid,
    input  lgs_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  wire                i_pop,
    output lgs_pkg::t_out_item o_out
);

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int RW1 = RW + 1;
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int XW  = $clog2(MAX_COLS);

    // grid storage, one word per row
    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rdata;
    logic                r_rvalid;
    logic [MAX_ROWS-1:0] r_valid;

    lgs_pkg::t_state     r_state;
    lgs_pkg::t_state     n_state;
    logic [31:0]         r_gen;
    logic [AW-1:0]       r_y;
    logic [MAX_COLS-1:0] r_prev;
    logic [MAX_COLS-1:0] r_cur;
    logic [MAX_COLS-1:0] r_first;
    logic                r_rd_ok;

    lgs_pkg::t_out_item  r_rq [2];
    logic                r_rwp;
    logic                r_rrp;
    logic [1:0]          r_rcnt;

    logic [RW-1:0]       w_nr;
    logic [CW-1:0]       w_nc;
    logic [XW-1:0]       w_last;
    logic [MAX_COLS-1:0] w_last_oh;
    logic [MAX_COLS-1:0] w_cmask;
    logic [MAX_COLS-1:0] w_rd;
    logic                w_more;
    logic [RW1-1:0]      w_y2;
    logic [MAX_COLS-1:0] w_nxt;
    logic [MAX_COLS-1:0] w_new;
    logic [MAX_COLS-1:0] w_vp, w_vc, w_vn;
    logic [MAX_COLS-1:0] w_lp, w_lc, w_ln;
    logic [MAX_COLS-1:0] w_rp, w_rc, w_rn;
    logic [3:0]          w_cnt [MAX_COLS];

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [MAX_COLS-1:0] w_wdata;
    logic [AW-1:0]       w_raddr;
    logic                w_push;
    logic [63:0]         w_res_row;
    logic                w_gen_inc;
    logic                w_clr_tail;
    logic                w_rpop;
    lgs_pkg::t_out_item  w_res;

    // area in use, out-of-range settings clamp to the legal range
    always_comb begin
        if (i_cfg_rows == 7'd0) begin
            w_nr = RW'(1);
        end else if (int'(i_cfg_rows) > MAX_ROWS) begin
            w_nr = RW'(MAX_ROWS);
        end else begin
            w_nr = RW'(i_cfg_rows);
        end
        if (i_cfg_cols == 7'd0) begin
            w_nc = CW'(1);
        end else if (int'(i_cfg_cols) > MAX_COLS) begin
            w_nc = CW'(MAX_COLS);
        end else begin
            w_nc = CW'(i_cfg_cols);
        end
    end

    assign w_last    = XW'(w_nc - CW'(1));
    assign w_last_oh = MAX_COLS'(1) << w_last;

    always_comb begin
        for (int i = 0; i < MAX_COLS; i++) begin
            w_cmask[i] = (i < int'(w_nc));
        end
    end

    assign w_rd   = r_rvalid ? r_rdata : '0;
    assign w_more = (RW1'(r_y) + RW1'(1)) < RW1'(w_nr);
    assign w_y2   = RW1'(r_y) + RW1'(2);
    assign w_nxt  = w_more ? w_rd : (i_cfg_wrap ? r_first : '0);

    // left and right neighbor vectors per row; wrap folds the column ends together
    always_comb begin
        w_vp = r_prev & w_cmask;
        w_vc = r_cur & w_cmask;
        w_vn = w_nxt & w_cmask;

        w_lp    = w_vp << 1;
        w_lp[0] = i_cfg_wrap & w_vp[w_last];
        w_lc    = w_vc << 1;
        w_lc[0] = i_cfg_wrap & w_vc[w_last];
        w_ln    = w_vn << 1;
        w_ln[0] = i_cfg_wrap & w_vn[w_last];

        w_rp = (w_vp >> 1) | ((i_cfg_wrap && w_vp[0]) ? w_last_oh : '0);
        w_rc = (w_vc >> 1) | ((i_cfg_wrap && w_vc[0]) ? w_last_oh : '0);
        w_rn = (w_vn >> 1) | ((i_cfg_wrap && w_vn[0]) ? w_last_oh : '0);
    end

    always_comb begin
        for (int x = 0; x < MAX_COLS; x++) begin
            w_cnt[x] = 4'(w_lp[x]) + 4'(w_vp[x]) + 4'(w_rp[x])
                     + 4'(w_lc[x]) + 4'(w_rc[x])
                     + 4'(w_ln[x]) + 4'(w_vn[x]) + 4'(w_rn[x]);
            w_new[x] = w_cmask[x] & lgs_pkg::life_rule(w_vc[x], w_cnt[x]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        w_we       = 1'b0;
        w_waddr    = AW'(i_cmd.row_index);
        w_wdata    = i_cmd.row_bits[MAX_COLS-1:0];
        w_raddr    = '0;
        w_push     = 1'b0;
        w_res_row  = '0;
        w_gen_inc  = 1'b0;
        w_clr_tail = 1'b0;
        case (r_state)
            lgs_pkg::ST_IDLE: begin
                if (i_cmd_valid && (r_rcnt != 2'd2)) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        lgs_pkg::OP_LOAD: begin
                            w_we   = i_cmd.row_ok;
                            w_push = 1'b1;
                        end
                        lgs_pkg::OP_READ: begin
                            w_raddr = AW'(i_cmd.row_index);
                            n_state = lgs_pkg::ST_READ;
                        end
                        lgs_pkg::OP_STEP: begin
                            w_raddr = AW'(w_nr - RW'(1));
                            n_state = lgs_pkg::ST_TOP;
                        end
                        default: begin
                            w_push = 1'b1;
                        end
                    endcase
                end
            end
            lgs_pkg::ST_READ: begin
                w_push    = 1'b1;
                w_res_row = r_rd_ok ? 64'(w_rd) : '0;
                n_state   = lgs_pkg::ST_IDLE;
            end
            lgs_pkg::ST_TOP: begin
                w_raddr = '0;
                n_state = lgs_pkg::ST_ROW0;
            end
            lgs_pkg::ST_ROW0: begin
                w_raddr = AW'(1);
                n_state = lgs_pkg::ST_SWEEP;
            end
            lgs_pkg::ST_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_y;
                w_wdata = w_new;
                w_raddr = (w_y2 < RW1'(MAX_ROWS)) ? AW'(w_y2) : '0;
                if (!w_more) begin
                    w_push     = 1'b1;
                    w_gen_inc  = 1'b1;
                    w_clr_tail = 1'b1;
                    n_state    = lgs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata  <= r_mem[w_raddr];
        r_rvalid <= r_valid[w_raddr];
    end

    // rows never written read as dead; a step drops rows below the area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_clr_tail) begin
                for (int i = 0; i < MAX_ROWS; i++) begin
                    if (i >= int'(w_nr)) begin
                        r_valid[i] <= 1'b0;
                    end
                end
            end
        end
    end

    // three-row window; old copies survive the write-back of the sweep
    always_ff @(posedge i_clk) begin
        case (r_state)
            lgs_pkg::ST_IDLE: begin
                if (o_cmd_pop) begin
                    r_rd_ok <= i_cmd.row_ok;
                end
            end
            lgs_pkg::ST_TOP: begin
                r_prev <= i_cfg_wrap ? w_rd : '0;
            end
            lgs_pkg::ST_ROW0: begin
                r_cur   <= w_rd;
                r_first <= w_rd;
                r_y     <= '0;
            end
            lgs_pkg::ST_SWEEP: begin
                r_prev <= r_cur;
                r_cur  <= w_nxt;
                r_y    <= r_y + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= '0;
        end else if (w_gen_inc) begin
            r_gen <= r_gen + 32'd1;
        end
    end

    assign w_res.row_out          = w_res_row;
    assign w_res.generation_count = w_gen_inc ? (r_gen + 32'd1) : r_gen;

    assign o_empty = (r_rcnt == 2'd0);
    assign o_out   = r_rq[r_rrp];
    assign w_rpop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_rq[r_rwp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwp  <= 1'b0;
            r_rrp  <= 1'b0;
            r_rcnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_rwp <= ~r_rwp;
            end
            if (w_rpop) begin
                r_rrp <= ~r_rrp;
            end
            r_rcnt <= r_rcnt + 2'(w_push) - 2'(w_rpop);
        end
    end

endmodule

`default_nettype wire

/* sv/life_grid_generation_step.sv */
// Life grid engine (rule B3/S23) over a grid of up to MAX_ROWS by MAX_COLS cells.
// Input channel: push/full. Each transaction loads a row, reads a row back or
// advances the grid one generation. Results: empty/pop, one result per input,
// in order, carrying the read row (zero otherwise) and the generation count.
// Config channel: valid/ready (always ready), index 0 wrap mode, 1 rows in
// use, 2 columns in use; write it only while the block is idle.
// A two-entry command queue feeds the execution engine, which owns the grid
// memory (one read and one write port) and a two-entry result queue.
// A load is done in the engine's idle state; a read passes through the read
// state; a step passes the top and row-0 states, then sweeps one row per cycle
// through the memory. The engine takes no new command until the last is done.
// Reset clears the grid to all dead at once, zeroes the generation count and
// sets full wrap-free 64 by 64 defaults. When the receiver stalls, results
// collect in the result queue, then commands in the command queue, then full
// rises.
`timescale 1ns / 1ps
`default_nettype none

module life_grid_generation_step #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  lgs_pkg::t_in_item  i_in,
    output logic               o_full,
    output logic               o_empty,
    input  wire                i_pop,
    output lgs_pkg::t_out_item o_out,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [6:0]         i_cfg_data
);

    logic          r_wrap;
    logic [6:0]    r_rows;
    logic [6:0]    r_cols;

    logic          w_cmd_valid;
    lgs_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= 1'b0;
            r_rows <= 7'd64;
            r_cols <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lgs_pkg::CFG_WRAP: r_wrap <= i_cfg_data[0];
                lgs_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                lgs_pkg::CFG_COLS: r_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lgs_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    lgs_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wrap  (r_wrap),
        .i_cfg_rows  (r_rows),
        .i_cfg_cols  (r_cols),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam logic [1:0] CFG_NONE     = 2'd3;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_push      = 1'b0;
    lgs_pkg::t_in_item  i_in        = '0;
    logic               i_pop       = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [6:0]         i_cfg_data  = '0;
    logic               o_full;
    logic               o_empty;
    logic               o_cfg_ready;
    lgs_pkg::t_out_item o_out;

    life_grid_generation_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predicted block state
    logic [63:0] life_now [64];
    logic [31:0] gen_now  = '0;
    logic        cfg_wrap = 1'b0;
    logic [6:0]  cfg_rows = 7'd64;
    logic [6:0]  cfg_cols = 7'd64;

    lgs_pkg::t_in_item  cmd_queue   [$];
    lgs_pkg::t_out_item awaited_out [$];
    int        issued       = 0;
    int        results_seen = 0;
    int        fail_count   = 0;
    int        gap_left     = 0;
    int        stall_left   = 0;
    logic      drv_burst    = 1'b0;
    logic      mon_burst    = 1'b0;
    int        items_made   = 0;

    initial begin
        for (int y = 0; y < 64; y++) life_now[y] = '0;
    end

    function automatic int clamp_span(logic [6:0] v);
        if (v == 7'd0) return 1;
        if (v > 7'd64) return 64;
        return int'(v);
    endfunction

    function automatic logic cell_seen(int y, int x, int nr, int nc);
        int yy, xx;
        yy = y;
        xx = x;
        if (cfg_wrap) begin
            yy = (y + nr) % nr;
            xx = (x + nc) % nc;
        end else if (y < 0 || y >= nr || x < 0 || x >= nc) begin
            return 1'b0;
        end
        return life_now[yy][xx];
    endfunction

    function automatic void advance_grid();
        logic [63:0] nxt [64];
        int nr, nc, n;
        logic alive;
        nr = clamp_span(cfg_rows);
        nc = clamp_span(cfg_cols);
        for (int y = 0; y < 64; y++) nxt[y] = '0;
        for (int y = 0; y < nr; y++) begin
            for (int x = 0; x < nc; x++) begin
                n = 0;
                alive = cell_seen(y, x, nr, nc);
                // neighbors counted one by one, so tiny wrapped areas count repeats
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if (dy != 0 || dx != 0) n += cell_seen(y + dy, x + dx, nr, nc);
                if (n == 3 || (alive && n == 2)) nxt[y][x] = 1'b1;
            end
        end
        for (int y = 0; y < 64; y++) life_now[y] = nxt[y];
        gen_now = gen_now + 32'd1;
    endfunction

    function automatic lgs_pkg::t_out_item grid_apply(lgs_pkg::t_in_item it);
        lgs_pkg::t_out_item r;
        r.row_out = '0;
        case (it.kind)
            lgs_pkg::KIND_LOAD: life_now[it.row_index] = it.row_bits;
            lgs_pkg::KIND_STEP: advance_grid();
            lgs_pkg::KIND_READ: r.row_out = life_now[it.row_index];
            default: ;
        endcase
        r.generation_count = gen_now;
        return r;
    endfunction

    // input driver
    always @(posedge i_clk) begin : drive_items
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                awaited_out.push_back(grid_apply(i_in));
                if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
                gap_left = drv_burst ? 0 : $urandom_range(0, 6);
            end
            if (!i_push || !o_full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_push <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    i_in   <= cmd_queue.pop_front();
                    i_push <= 1'b1;
                    issued++;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin : watch_results
        lgs_pkg::t_out_item want;
        logic pop_next;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (awaited_out.size() == 0) begin
                    $error("result transaction with nothing awaited: %s %h %s %0d",
                           "row_out", o_out.row_out,
                           "generation_count", o_out.generation_count);
                    fail_count++;
                end else begin
                    want = awaited_out.pop_front();
                    if (o_out.row_out !== want.row_out) begin
                        $error("row_out mismatch: expected %h, actual %h",
                               want.row_out, o_out.row_out);
                        fail_count++;
                    end
                    if (o_out.generation_count !== want.generation_count) begin
                        $error("generation_count mismatch: expected %0d, actual %0d",
                               want.generation_count, o_out.generation_count);
                        fail_count++;
                    end
                end
                results_seen++;
                if ($urandom_range(0, 39) == 0) mon_burst = !mon_burst;
                stall_left = mon_burst ? 0 : $urandom_range(0, 6);
            end
            if (stall_left > 0) begin
                stall_left--;
                pop_next = 1'b0;
            end else begin
                pop_next = 1'b1;
            end
            i_pop <= pop_next;
        end
    end

    task automatic add_item(input logic [1:0] kind, input logic [5:0] row,
                            input logic [63:0] bits);
        lgs_pkg::t_in_item it;
        it.kind      = kind;
        it.row_index = row;
        it.row_bits  = bits;
        cmd_queue.push_back(it);
        items_made++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            lgs_pkg::CFG_WRAP: cfg_wrap = val[0];
            lgs_pkg::CFG_ROWS: cfg_rows = val;
            lgs_pkg::CFG_COLS: cfg_cols = val;
            default: ;
        endcase
    endtask

    task automatic set_area(input logic wrap, input logic [6:0] rows, input logic [6:0] cols);
        logic [5:0] junk;
        junk = 6'($urandom);
        write_reg(lgs_pkg::CFG_WRAP, {junk, wrap});
        write_reg(lgs_pkg::CFG_ROWS, rows);
        write_reg(lgs_pkg::CFG_COLS, cols);
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || issued != results_seen) @(posedge i_clk);
        // every issued item has its result back, so no step is still in its sweep
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_row();
        int nr;
        nr = clamp_span(cfg_rows);
        if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, nr - 1));
    endfunction

    function automatic logic [63:0] pick_bits();
        logic [63:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return a;
            1: return a & b;
            2: return a | b;
            default: return {61'd0, 3'($urandom)} << $urandom_range(0, 61);
        endcase
    endfunction

    // mostly load/step/read sequences inside the area, some noise
    task automatic fill_phase(input int budget);
        int start;
        start = items_made;
        while (items_made - start < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(1, 6))
                    add_item(lgs_pkg::KIND_LOAD, pick_row(), pick_bits());
                repeat ($urandom_range(1, 3)) begin
                    add_item(lgs_pkg::KIND_STEP, 6'($urandom), {$urandom, $urandom});
                    repeat ($urandom_range(1, 3))
                        add_item(lgs_pkg::KIND_READ, pick_row(), {$urandom, $urandom});
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    add_item(2'($urandom), 6'($urandom), {$urandom, $urandom});
            end
        end
    endtask

    initial begin : timeout
        #(2_000_000);
        $display("life_grid_generation_step test failed");
        $finish;
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_NONE, 7'h7f);

        // default area, edges and reset state
        add_item(lgs_pkg::KIND_READ, 6'd0, '0);
        add_item(lgs_pkg::KIND_LOAD, 6'd0, '1);
        add_item(lgs_pkg::KIND_LOAD, 6'd63, '1);
        add_item(lgs_pkg::KIND_LOAD, 6'd31, 64'h8000_0000_0000_0001);
        add_item(KIND_UNKNOWN, 6'd63, '1);
        add_item(lgs_pkg::KIND_READ, 6'd63, '1);
        add_item(lgs_pkg::KIND_STEP, 6'd0, '0);
        add_item(lgs_pkg::KIND_READ, 6'd0, '0);
        add_item(lgs_pkg::KIND_READ, 6'd1, '0);
        add_item(lgs_pkg::KIND_READ, 6'd63, '0);
        wait_idle();

        // single cell wrapped onto itself
        set_area(1'b1, 7'd1, 7'd1);
        add_item(lgs_pkg::KIND_LOAD, 6'd0, 64'h1);
        add_item(lgs_pkg::KIND_LOAD, 6'd1, '1);
        add_item(lgs_pkg::KIND_STEP, 6'd0, '0);
        add_item(lgs_pkg::KIND_READ, 6'd0, '0);
        add_item(lgs_pkg::KIND_READ, 6'd1, '0);
        wait_idle();

        set_area(1'b1, 7'd2, 7'd2);
        add_item(lgs_pkg::KIND_LOAD, 6'd0, 64'h3);
        add_item(lgs_pkg::KIND_LOAD, 6'd1, 64'h1);
        add_item(lgs_pkg::KIND_STEP, 6'd0, '0);
        add_item(lgs_pkg::KIND_READ, 6'd0, '0);
        wait_idle();

        // cells outside the area get cleared
        set_area(1'b0, 7'd10, 7'd10);
        add_item(lgs_pkg::KIND_LOAD, 6'd5, '1);
        add_item(lgs_pkg::KIND_STEP, 6'd0, '0);
        add_item(lgs_pkg::KIND_READ, 6'd5, '0);
        wait_idle();

        // zero and oversize area values
        set_area(1'b1, 7'd0, 7'd127);
        add_item(lgs_pkg::KIND_LOAD, 6'd0, '1);
        add_item(lgs_pkg::KIND_STEP, 6'd0, '0);
        add_item(lgs_pkg::KIND_READ, 6'd0, '0);
        wait_idle();

        set_area(1'b0, 7'd64, 7'd64);
        fill_phase(110);
        wait_idle();
        set_area(1'b1, 7'd64, 7'd64);
        fill_phase(110);
        wait_idle();
        set_area(1'b1, 7'd1, 7'd64);
        fill_phase(90);
        wait_idle();
        set_area(1'b0, 7'd127, 7'd1);
        fill_phase(90);
        wait_idle();
        set_area(1'b1, 7'd3, 7'd3);
        fill_phase(90);
        wait_idle();
        set_area(1'b0, 7'd2, 7'd0);
        fill_phase(90);
        wait_idle();
        repeat (7) begin
            set_area(1'($urandom), 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            fill_phase(95);
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && awaited_out.size() == 0) begin
            $display("life_grid_generation_step test passed");
        end else begin
            $display("life_grid_generation_step test failed");
        end
        $finish;
    end

endmodule
